### design/thf_pkg.sv
// Shared types, constants and register codes of the threshold hit finder.
package thf_pkg;

   // Default configuration of the block.
   localparam int MAX_SAMPLES_DEFAULT = 16384;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Field widths.
   localparam int SAMPLE_W  = 16;
   localparam int NOISE_W   = 15;
   localparam int CHAN_W    = 16;
   localparam int START_W   = 20;
   localparam int CHARGE_W  = 32;
   localparam int TICKS_W   = 21;
   localparam int SIGMA_W   = 10;
   localparam int FACTOR_W  = 7;
   localparam int DIVISOR_W = 16;
   localparam int CSR_IDX_W = 2;

   // Register reset values.
   localparam logic [SIGMA_W-1:0]   SIGMA_RESET   = 10'd80;
   localparam logic [FACTOR_W-1:0]  FACTOR_RESET  = 7'd1;
   localparam logic [DIVISOR_W-1:0] DIVISOR_RESET = 16'd1;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_SIGMA_THRESHOLD   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DOWNSAMPLE_FACTOR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHARGE_DIVISOR    = 2'd2;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic [NOISE_W-1:0]         noise;
      logic [CHAN_W-1:0]          channel;
      logic                       end_of_waveform;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0]          hit_channel;
      logic [START_W-1:0]         start_time;
      logic signed [CHARGE_W-1:0] hit_charge;
      logic [TICKS_W-1:0]         time_over_threshold;
   } rsp_type;

   // A closed hit before its charge is divided.
   typedef struct packed {
      logic [CHAN_W-1:0]          chan;
      logic [START_W-1:0]         start;
      logic signed [CHARGE_W-1:0] charge;
      logic [TICKS_W-1:0]         ticks;
   } hit_type;

   typedef struct packed {
      logic [SIGMA_W-1:0]   sigma_threshold;
      logic [FACTOR_W-1:0]  downsample_factor;
      logic [DIVISOR_W-1:0] charge_divisor;
   } cfg_type;

endpackage

### design/thf_front.sv
// Front end: threshold test and hit accumulation, one sample per cycle while the queue has room.
module thf_front #(
   parameter int MAX_SAMPLES = thf_pkg::MAX_SAMPLES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  thf_pkg::cfg_type cfg,
   input  logic             req_push,
   input  thf_pkg::req_type req_data,
   input  logic             q_full,
   output logic             hit_push,
   output thf_pkg::hit_type hit_data
);

   localparam int IDX_W = $clog2(MAX_SAMPLES);

   logic                 accept;
   logic                 in_hit_ff, in_hit_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W:0]       idx_inc;
   logic [thf_pkg::START_W-1:0]  start_ff, start_in;
   logic signed [thf_pkg::CHARGE_W-1:0] charge_ff, charge_in;
   logic [thf_pkg::TICKS_W-1:0]  ticks_ff, ticks_in;
   logic [thf_pkg::CHAN_W-1:0]   chan_ff, chan_in;

   logic signed [thf_pkg::SAMPLE_W-1:0] samp;
   logic [26:0]          scaled_sample;
   logic [24:0]          thr_prod;
   logic [26:0]          thr_ext;
   logic                 over;
   logic [19:0]          idx_ext;
   logic [26:0]          start_prod;
   logic signed [23:0]   charge_prod;
   logic signed [32:0]   charge_sum;
   logic signed [thf_pkg::CHARGE_W-1:0] charge_sat;
   logic [21:0]          ticks_sum;
   logic [thf_pkg::TICKS_W-1:0] ticks_sat;

   assign accept = req_push && !q_full;
   assign samp   = req_data.sample;

   // Sample times 16 against threshold times noise, both in 27-bit signed form.
   assign scaled_sample = {{7{samp[15]}}, samp, 4'b0000};
   assign thr_prod      = 25'(cfg.sigma_threshold) * 25'(req_data.noise);
   assign thr_ext       = {2'b00, thr_prod};
   assign over          = $signed(scaled_sample) > $signed(thr_ext);

   assign idx_ext    = 20'(idx_ff);
   assign start_prod = 27'(idx_ext) * 27'(cfg.downsample_factor);

   assign charge_prod = 24'(samp) * 24'($signed({1'b0, cfg.downsample_factor}));
   assign charge_sum  = 33'(charge_ff) + 33'(charge_prod);
   always_comb begin
      if (charge_sum[32] != charge_sum[31]) begin
         charge_sat = charge_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         charge_sat = charge_sum[31:0];
      end
   end

   assign ticks_sum = 22'(ticks_ff) + 22'(cfg.downsample_factor);
   assign ticks_sat = ticks_sum[21] ? {thf_pkg::TICKS_W{1'b1}} : ticks_sum[20:0];

   assign idx_inc = (IDX_W+1)'(idx_ff) + (IDX_W+1)'(1);

   always_comb begin
      in_hit_in = in_hit_ff;
      idx_in    = idx_ff;
      start_in  = start_ff;
      charge_in = charge_ff;
      ticks_in  = ticks_ff;
      chan_in   = chan_ff;
      hit_push  = 1'b0;
      if (accept) begin
         if (req_data.end_of_waveform) begin
            in_hit_in = 1'b0;
            idx_in    = '0;
         end else begin
            if (over && !in_hit_ff) begin
               start_in  = start_prod[19:0];
               charge_in = 32'(samp);
               ticks_in  = 21'(cfg.downsample_factor);
               chan_in   = req_data.channel;
               in_hit_in = 1'b1;
            end else if (over) begin
               charge_in = charge_sat;
               ticks_in  = ticks_sat;
            end else if (in_hit_ff) begin
               hit_push  = 1'b1;
               in_hit_in = 1'b0;
            end
            idx_in = (idx_inc >= (IDX_W+1)'(MAX_SAMPLES)) ? '0 : idx_inc[IDX_W-1:0];
         end
      end
   end

   assign hit_data.chan   = chan_ff;
   assign hit_data.start  = start_ff;
   assign hit_data.charge = charge_ff;
   assign hit_data.ticks  = ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_hit_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         in_hit_ff <= in_hit_in;
         idx_ff    <= idx_in;
      end
      start_ff  <= start_in;
      charge_ff <= charge_in;
      ticks_ff  <= ticks_in;
      chan_ff   <= chan_in;
   end

endmodule

### design/thf_hit_queue.sv
// Short queue of closed hits between the front end and the divider.
module thf_hit_queue #(
   parameter int DEPTH = thf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  thf_pkg::hit_type push_data,
   output logic             full,
   input  logic             pop,
   output thf_pkg::hit_type pop_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   thf_pkg::hit_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = count_ff == CNT_W'(DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### design/thf_back.sv
// Back end: serial charge divider and the result output register.
module thf_back (
   input  logic             clock,
   input  logic             reset,
   input  thf_pkg::cfg_type cfg,
   input  logic             q_empty,
   input  thf_pkg::hit_type q_data,
   output logic             q_pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output thf_pkg::rsp_type rsp_data
);

   typedef enum logic [2:0] {
      BK_IDLE = 3'b001,
      BK_DIV  = 3'b010,
      BK_HOLD = 3'b100
   } back_state_type;

   back_state_type state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [15:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [15:0] div_ff, div_in;
   logic        neg_ff, neg_in;
   logic [thf_pkg::CHAN_W-1:0]  chan_ff, chan_in;
   logic [thf_pkg::START_W-1:0] start_ff, start_in;
   logic [thf_pkg::TICKS_W-1:0] ticks_ff, ticks_in;
   logic        rsp_valid_ff, rsp_valid_in;
   thf_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [16:0] shifted;
   logic [17:0] diff;
   logic        ge;
   logic [31:0] magnitude;
   logic [31:0] quotient;

   // One restoring step per cycle; the remainder always stays below the divisor.
   assign shifted   = {rem_ff, quo_ff[31]};
   assign diff      = {1'b0, shifted} - {2'b00, div_ff};
   assign ge        = !diff[17];
   assign magnitude = q_data.charge[31] ? 32'(-q_data.charge) : q_data.charge;
   assign quotient  = neg_ff ? 32'(-quo_ff) : quo_ff;

   assign q_pop     = (state_ff == BK_IDLE) && !q_empty;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      div_in       = div_ff;
      neg_in       = neg_ff;
      chan_in      = chan_ff;
      start_in     = start_ff;
      ticks_in     = ticks_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               rem_in   = '0;
               quo_in   = magnitude;
               div_in   = (cfg.charge_divisor == '0) ? 16'd1 : cfg.charge_divisor;
               neg_in   = q_data.charge[31];
               chan_in  = q_data.chan;
               start_in = q_data.start;
               ticks_in = q_data.ticks;
               cnt_in   = 5'd31;
               state_in = BK_DIV;
            end
         end
         BK_DIV: begin
            rem_in = ge ? diff[15:0] : shifted[15:0];
            quo_in = {quo_ff[30:0], ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = BK_HOLD;
            end
         end
         BK_HOLD: begin
            if (!rsp_valid_ff || rsp_pop) begin
               rsp_valid_in                    = 1'b1;
               rsp_data_in.hit_channel         = chan_ff;
               rsp_data_in.start_time          = start_ff;
               rsp_data_in.hit_charge          = quotient;
               rsp_data_in.time_over_threshold = ticks_ff;
               state_in                        = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff      <= cnt_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      div_ff      <= div_in;
      neg_ff      <= neg_in;
      chan_ff     <= chan_in;
      start_ff    <= start_in;
      ticks_ff    <= ticks_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### design/threshold_hit_finder.sv
// Top level of the time-over-threshold hit finder: registers, front end, queue, divider.
//
// The hit finder takes one ADC sample word per clock on the req_ side and reports each
// finished hit as one word on the rsp_ side. A sample is over threshold when sample times 16
// exceeds sigma_threshold (unsigned, four fraction bits) times the noise estimate; a run of
// over-threshold samples forms a hit whose charge, start time and time over threshold are
// accumulated in the front end in the same cycle the sample is taken. When the run ends,
// the closed hit goes into a queue of QUEUE_DEPTH entries, and the back end divides its
// charge by charge_divisor with a restoring divider that retires one quotient bit per
// cycle; each hit is loaded from the queue, goes through 32 division steps and then
// moves into the output register as long as the output register is free; while an
// unread result sits there, the back end waits. Samples are therefore accepted every cycle
// while the queue has room; full rises when hits close faster than the back end drains
// them (one hit at a time, slower while results wait unread) for longer than the queue
// can absorb. A sample word with end_of_waveform set is not tested, resets the sample index
// and drops any open hit. Configuration writes are always accepted (csr_ready is tied high)
// and must only be issued while the block is idle.
module threshold_hit_finder #(
   parameter int MAX_SAMPLES = thf_pkg::MAX_SAMPLES_DEFAULT,
   parameter int QUEUE_DEPTH = thf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // Sample input queue side.
   input  logic                              req_push,
   output logic                              req_full,
   input  thf_pkg::req_type                  req_data,
   // Hit output queue side.
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output thf_pkg::rsp_type                  rsp_data,
   // Configuration write channel.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [thf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [thf_pkg::DIVISOR_W-1:0]     csr_data
);

   logic [thf_pkg::SIGMA_W-1:0]   sigma_ff, sigma_in;
   logic [thf_pkg::FACTOR_W-1:0]  factor_ff, factor_in;
   logic [thf_pkg::DIVISOR_W-1:0] divisor_ff, divisor_in;
   thf_pkg::cfg_type              cfg;

   logic             hit_push;
   thf_pkg::hit_type hit_data;
   logic             hit_full;
   logic             hit_pop;
   thf_pkg::hit_type hit_head;
   logic             hit_empty;

   // Configuration registers. Writes to an unused index are accepted and ignored.
   assign csr_ready = 1'b1;

   always_comb begin
      sigma_in   = sigma_ff;
      factor_in  = factor_ff;
      divisor_in = divisor_ff;
      if (csr_valid) begin
         unique case (csr_index)
            thf_pkg::CSR_SIGMA_THRESHOLD:   sigma_in   = csr_data[thf_pkg::SIGMA_W-1:0];
            thf_pkg::CSR_DOWNSAMPLE_FACTOR: factor_in  = csr_data[thf_pkg::FACTOR_W-1:0];
            thf_pkg::CSR_CHARGE_DIVISOR:    divisor_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff   <= thf_pkg::SIGMA_RESET;
         factor_ff  <= thf_pkg::FACTOR_RESET;
         divisor_ff <= thf_pkg::DIVISOR_RESET;
      end else begin
         sigma_ff   <= sigma_in;
         factor_ff  <= factor_in;
         divisor_ff <= divisor_in;
      end
   end

   assign cfg.sigma_threshold   = sigma_ff;
   assign cfg.downsample_factor = factor_ff;
   assign cfg.charge_divisor    = divisor_ff;

   // The input side stalls whenever the hit queue is full, since any word may close a hit.
   assign req_full = hit_full;

   thf_front #(
      .MAX_SAMPLES(MAX_SAMPLES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_push (req_push),
      .req_data (req_data),
      .q_full   (hit_full),
      .hit_push (hit_push),
      .hit_data (hit_data)
   );

   thf_hit_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (hit_push),
      .push_data (hit_data),
      .full      (hit_full),
      .pop       (hit_pop),
      .pop_data  (hit_head),
      .empty     (hit_empty)
   );

   thf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_empty   (hit_empty),
      .q_data    (hit_head),
      .q_pop     (hit_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

   // The output register is empty in the cycle after reset.
   assert property (@(posedge clock) $past(reset) |-> rsp_empty)
      else $error("result visible right after reset");

   // The front end never closes a hit into a full queue.
   assert property (@(posedge clock) disable iff (reset) hit_push |-> !hit_full)
      else $error("hit pushed into full queue");

   // An end-of-waveform word never closes a hit.
   assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full && req_data.end_of_waveform) |-> !hit_push)
      else $error("end-of-waveform word produced a hit");

   // The divider takes a new hit only when the queue holds one.
   assert property (@(posedge clock) disable iff (reset) hit_pop |-> !hit_empty)
      else $error("divider popped an empty queue");

endmodule

### tb/sv/testbench.sv
// Self-checking testbench of the threshold hit finder: directed table, random pulse trains.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import thf_pkg::*;

   // The block treats an unused register index as a plain no-op.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   localparam int MAX_SAMPLES = MAX_SAMPLES_DEFAULT;
   localparam int TICKS_MAX = 2 ** TICKS_W - 1;
   localparam longint CHARGE_MAX = 64'sd2147483647;
   localparam longint CHARGE_MIN = -64'sd2147483648;

   // Quiet time after the last owed hit, so that the back end has finished anything it still
   // holds before the registers change.
   localparam int SETTLE_CYCLES = 40;
   // At the end the queue may still hold a few hits behind the divider.
   localparam int DRAIN_CYCLES = QUEUE_DEPTH_DEFAULT * 40;
   // The longest correct quiet stretch is the receiver hold-off below plus a drain.
   localparam int HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 4000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_push = 1'b0;
   logic             req_full;
   req_type          req_data = '0;
   logic             rsp_empty;
   logic             rsp_pop = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DIVISOR_W-1:0] csr_data = '0;

   threshold_hit_finder dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Our own copy of the registers, as the block should hold them.
   logic [SIGMA_W-1:0]   cfg_sigma   = SIGMA_RESET;
   logic [FACTOR_W-1:0]  cfg_factor  = FACTOR_RESET;
   logic [DIVISOR_W-1:0] cfg_divisor = DIVISOR_RESET;

   // Our own copy of the hit being built.
   bit                   open_hit   = 1'b0;
   int                   idx_now    = 0;
   logic [START_W-1:0]   start_reg  = '0;
   int                   charge_acc = 0;
   int                   ticks_acc  = 0;
   logic [CHAN_W-1:0]    chan_reg   = '0;

   // Hits the block still owes us, oldest first.
   rsp_type pending_hits [$];

   int errors = 0;
   int words_taken = 0;
   int hits_seen = 0;
   int settings_used = 1;
   int quiet_cycles = 0;

   // Stimulus pacing, shared by the sender, the receiver and the main sequence.
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_left = 0;

   // Random pulse train state: samples left in the current pulse and in the gap after it.
   int pulse_left = 0;
   int gap_left = 0;

   // Works out what the block must emit for one accepted sample word, and advances our
   // copy of its state. Returns 1 when the word closes a hit.
   function automatic bit find_hit(input req_type w, output rsp_type hit);
      longint s;
      longint acc;
      longint div;
      int t;
      bit over;
      bit done;
      done = 1'b0;
      hit = '0;
      // An end-of-waveform word is never tested; it just rewinds and forgets the open hit.
      if (w.end_of_waveform) begin
         open_hit = 1'b0;
         idx_now = 0;
         return 1'b0;
      end
      s = longint'($signed(w.sample));
      over = (s * 16) > (longint'(cfg_sigma) * longint'(w.noise));
      if (over && !open_hit) begin
         start_reg = START_W'(idx_now * int'(cfg_factor));
         charge_acc = int'(s);
         ticks_acc = int'(cfg_factor);
         chan_reg = w.channel;
         open_hit = 1'b1;
      end else if (over) begin
         acc = longint'(charge_acc) + s * longint'(cfg_factor);
         if (acc > CHARGE_MAX) begin
            acc = CHARGE_MAX;
         end else if (acc < CHARGE_MIN) begin
            acc = CHARGE_MIN;
         end
         charge_acc = int'(acc);
         t = ticks_acc + int'(cfg_factor);
         ticks_acc = (t > TICKS_MAX) ? TICKS_MAX : t;
      end else if (open_hit) begin
         // A zero divisor passes the charge through; SV division truncates toward zero.
         div = (cfg_divisor == 0) ? 64'sd1 : longint'(cfg_divisor);
         hit.hit_channel = chan_reg;
         hit.start_time = start_reg;
         hit.hit_charge = CHARGE_W'(longint'(charge_acc) / div);
         hit.time_over_threshold = TICKS_W'(ticks_acc);
         open_hit = 1'b0;
         done = 1'b1;
      end
      idx_now = (idx_now + 1 >= MAX_SAMPLES) ? 0 : idx_now + 1;
      return done;
   endfunction

   // A sample word with a random payload and the end-of-waveform flag set.
   function automatic req_type eow_word();
      req_type w;
      w.sample = SAMPLE_W'($urandom);
      w.noise = NOISE_W'($urandom);
      w.channel = CHAN_W'($urandom);
      w.end_of_waveform = 1'b1;
      return w;
   endfunction

   // A sample word that lands on the requested side of the threshold under the current
   // registers, often right at the boundary.
   function automatic req_type shaped_word(input bit want_over);
      req_type w;
      int thr_q;
      int edge_val;
      int pick;
      w.channel = CHAN_W'($urandom);
      w.end_of_waveform = 1'b0;
      pick = $urandom_range(2);
      if (want_over) begin
         // Small noise keeps the threshold reachable even at the largest sigma.
         w.noise = NOISE_W'($urandom_range(0, 500));
         thr_q = (int'(cfg_sigma) * int'(w.noise)) / 16;
         edge_val = thr_q + 1;
         if (pick == 0) begin
            w.sample = SAMPLE_W'(edge_val);
         end else if (pick == 1) begin
            w.sample = SAMPLE_W'(edge_val + int'($urandom_range(0, 15)));
         end else begin
            w.sample = SAMPLE_W'(int'($urandom_range(edge_val, 32767)));
         end
      end else begin
         w.noise = ($urandom_range(3) == 0) ? NOISE_W'($urandom)
                                            : NOISE_W'($urandom_range(0, 500));
         thr_q = (int'(cfg_sigma) * int'(w.noise)) / 16;
         edge_val = (thr_q > 32767) ? 32767 : thr_q;
         if (pick == 0) begin
            w.sample = SAMPLE_W'(edge_val);
         end else begin
            w.sample = SAMPLE_W'(edge_val - int'($urandom_range(0, edge_val + 32768)));
         end
      end
      return w;
   endfunction

   // Next random word: mostly pulse trains of over-threshold samples separated by quiet
   // gaps, with some fully random words and the odd end of waveform mixed in.
   function automatic req_type next_word();
      req_type w;
      int roll;
      roll = $urandom_range(99);
      if (roll < 2) begin
         w = eow_word();
      end else if (roll < 7) begin
         w.sample = SAMPLE_W'($urandom);
         w.noise = NOISE_W'($urandom);
         w.channel = CHAN_W'($urandom);
         w.end_of_waveform = 1'b0;
      end else begin
         if (pulse_left == 0 && gap_left == 0) begin
            pulse_left = ($urandom_range(9) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 6);
            gap_left = $urandom_range(1, 5);
         end
         if (pulse_left > 0) begin
            pulse_left--;
            w = shaped_word(1'b1);
         end else begin
            gap_left--;
            w = shaped_word(1'b0);
         end
      end
      return w;
   endfunction

   // Offers one sample word until the block takes it, with random idle cycles in front.
   // A pinned row supplies its expected hit directly instead of the predicted one.
   task automatic offer_word(input req_type w, input bit pinned, input rsp_type pinned_hit);
      bit taken;
      rsp_type hit;
      taken = 1'b0;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= w;
      while (!taken) begin
         @(posedge clock);
         if (!req_full) begin
            taken = 1'b1;
         end else begin
            @(negedge clock);
         end
      end
      words_taken++;
      if (find_hit(w, hit) || pinned) begin
         pending_hits.insert(pending_hits.size(), pinned ? pinned_hit : hit);
      end
   endtask

   // Writes one register over the configuration channel and mirrors it.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DIVISOR_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_SIGMA_THRESHOLD: begin
            cfg_sigma = value[SIGMA_W-1:0];
         end
         CSR_DOWNSAMPLE_FACTOR: begin
            cfg_factor = value[FACTOR_W-1:0];
         end
         CSR_CHARGE_DIVISOR: begin
            cfg_divisor = value;
         end
         default: begin
         end
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stops offering, lets every owed hit come out, then gives the divider time to go quiet.
   task automatic finish_phase();
      @(negedge clock);
      req_push <= 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   // Receiver: pops at random, or not at all while a hold-off is running. The hold-off is
   // counted down here, one cycle per falling edge.
   always @(negedge clock) begin
      if (reset || hold_left > 0) begin
         rsp_pop <= 1'b0;
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
         end
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Scoreboard: every popped hit must match the oldest hit we predicted.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         hits_seen++;
         if (pending_hits.size() == 0) begin
            errors++;
            $display("%0t: unexpected hit, channel %0d start %0d charge %0d ticks %0d",
                     $time, rsp_data.hit_channel, rsp_data.start_time,
                     $signed(rsp_data.hit_charge), rsp_data.time_over_threshold);
         end else begin
            want = pending_hits.pop_front();
            check_field("hit_channel", want.hit_channel, rsp_data.hit_channel);
            check_field("start_time", want.start_time, rsp_data.start_time);
            check_field("hit_charge", $signed(want.hit_charge), $signed(rsp_data.hit_charge));
            check_field("time_over_threshold", want.time_over_threshold,
                        rsp_data.time_over_threshold);
         end
      end
   end

   // Watchdog: ends the run when no word moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no word moved for %0d cycles, %0d hits still owed",
                  $time, WATCHDOG_LIMIT, pending_hits.size());
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Directed rows, run with the registers at their reset values (sigma 5.0, factor 1,
   // divisor 1). Rows with a pinned hit carry their answer; the rest use the predictor.
   typedef struct packed {
      req_type word;
      logic    pinned;
      rsp_type pinned_hit;
   } dir_row_type;

   localparam dir_row_type DIRECTED [0:14] = '{
      // Largest sample with zero noise opens a hit at index 0 on the top channel.
      '{'{16'h7FFF, 15'h0000, 16'hFFFF, 1'b0}, 1'b0, '0},
      // Most negative sample with the largest noise closes it unchanged.
      '{'{16'h8000, 15'h7FFF, 16'h0000, 1'b0}, 1'b1,
        '{16'hFFFF, 20'd0, 32'sd32767, 21'd1}},
      // Exactly on the threshold (100 * 16 == 80 * 20) does not count as over.
      '{'{16'd100, 15'd20, 16'd5, 1'b0}, 1'b0, '0},
      // One above the threshold opens a hit at index 3 on channel 7.
      '{'{16'd101, 15'd20, 16'd7, 1'b0}, 1'b0, '0},
      // A later sample with another channel must not change the hit's channel.
      '{'{16'd200, 15'd0, 16'd9, 1'b0}, 1'b0, '0},
      // Zero against zero noise is under threshold and closes the hit.
      '{'{16'd0, 15'd0, 16'd1, 1'b0}, 1'b1,
        '{16'd7, 20'd3, 32'sd301, 21'd2}},
      // End of waveform on a sample that would be over: ignored, index rewinds.
      '{'{16'h7FFF, 15'd0, 16'd2, 1'b1}, 1'b0, '0},
      '{'{16'd50, 15'd1, 16'd3, 1'b0}, 1'b0, '0},
      // End of waveform drops the open hit, so the next quiet sample emits nothing.
      '{'{16'd0, 15'd0, 16'd0, 1'b1}, 1'b0, '0},
      '{'{16'd0, 15'h7FFF, 16'd0, 1'b0}, 1'b0, '0},
      '{'{16'h7FFF, 15'h7FFF, 16'hAAAA, 1'b0}, 1'b0, '0},
      '{'{16'hFFFF, 15'd0, 16'h5555, 1'b0}, 1'b0, '0},
      '{'{16'd1, 15'd0, 16'h1234, 1'b0}, 1'b0, '0},
      '{'{16'h7FFF, 15'd1, 16'h4321, 1'b0}, 1'b0, '0},
      '{'{16'h8000, 15'd0, 16'd0, 1'b0}, 1'b0, '0}
   };

   // Register settings and pacing of the random phases. A drawn row takes random register
   // values; a squeezed row holds the receiver off so the queue fills and full rises.
   typedef struct packed {
      logic [15:0] sigma;
      logic [15:0] factor;
      logic [15:0] divisor;
      logic [7:0]  send_pct;
      logic [7:0]  recv_pct;
      logic [15:0] words;
      logic        squeeze;
      logic        drawn;
   } plan_row_type;

   localparam plan_row_type PLAN [0:5] = '{
      '{16'd80,    16'd1,     16'd1,     8'd0,  8'd0,  16'd130, 1'b0, 1'b0},
      '{16'd1023,  16'd64,    16'd65535, 8'd64, 8'd0,  16'd130, 1'b0, 1'b0},
      // Zero sigma, zero factor and zero divisor all at once.
      '{16'd0,     16'd0,     16'd0,     8'd0,  8'd64, 16'd130, 1'b0, 1'b0},
      // All ones in sigma and factor: only the low bits of each should stick (sigma 1023, factor 127).
      '{16'hFFFF,  16'hFFFF,  16'd3,     8'd10, 8'd10, 16'd130, 1'b0, 1'b0},
      '{16'd16,    16'd5,     16'd7,     8'd0,  8'd0,  16'd130, 1'b1, 1'b0},
      '{16'd0,     16'd0,     16'd0,     8'd10, 8'd10, 16'd130, 1'b0, 1'b1}
   };

   initial begin
      int n;
      int p;
      logic [15:0] sigma_val;
      logic [15:0] factor_val;
      logic [15:0] divisor_val;
      rsp_type no_hit;
      no_hit = '0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (n = 0; n < $size(DIRECTED); n++) begin
         offer_word(DIRECTED[n].word, DIRECTED[n].pinned, DIRECTED[n].pinned_hit);
      end
      finish_phase();

      for (p = 0; p < $size(PLAN); p++) begin
         if (PLAN[p].drawn) begin
            sigma_val = 16'($urandom_range(0, 1023));
            factor_val = 16'($urandom_range(1, 64));
            divisor_val = 16'($urandom_range(1, 65535));
         end else begin
            sigma_val = PLAN[p].sigma;
            factor_val = PLAN[p].factor;
            divisor_val = PLAN[p].divisor;
         end
         write_reg(CSR_SIGMA_THRESHOLD, sigma_val);
         write_reg(CSR_DOWNSAMPLE_FACTOR, factor_val);
         write_reg(CSR_CHARGE_DIVISOR, divisor_val);
         // Writes to the spare index must leave every register alone.
         write_reg(CSR_UNUSED, 16'($urandom));
         settings_used++;
         send_idle_pct = PLAN[p].send_pct;
         recv_stall_pct = PLAN[p].recv_pct;
         if (PLAN[p].squeeze) begin
            hold_left = HOLD_CYCLES;
         end
         repeat (int'(PLAN[p].words)) offer_word(next_word(), 1'b0, no_hit);
         finish_phase();
      end

      // One long hit at the largest factor: it stays over long enough for the charge to
      // saturate, then an explicit quiet sample closes it.
      write_reg(CSR_SIGMA_THRESHOLD, 16'd80);
      write_reg(CSR_DOWNSAMPLE_FACTOR, 16'd127);
      write_reg(CSR_CHARGE_DIVISOR, 16'd1);
      settings_used++;
      offer_word(eow_word(), 1'b0, no_hit);
      repeat (10) offer_word(shaped_word(1'b0), 1'b0, no_hit);
      repeat (560) begin
         offer_word('{SAMPLE_W'(int'($urandom_range(32000, 32767))),
                      NOISE_W'($urandom_range(0, 3)), CHAN_W'($urandom), 1'b0},
                    1'b0, no_hit);
      end
      offer_word(shaped_word(1'b0), 1'b0, no_hit);
      repeat (20) offer_word(next_word(), 1'b0, no_hit);
      finish_phase();

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Summary: %0d sample words under %0d register settings, %0d hits checked.",
               words_taken, settings_used, hits_seen);
      $display("Summary: included a full-queue stall and a long hit with saturated charge.");
      if (errors == 0 && pending_hits.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches, %0d hits never arrived", errors, pending_hits.size());
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
